/* design/lzwd_pkg.sv */
`timescale 1ns / 1ps
package lzwd_pkg;

    localparam int DICT_ENTRIES = 512;
    localparam int CODE_W       = 16;
    localparam int SYM_W        = 9;
    localparam int NFE_W        = 10;
    localparam int CAP_W        = 24;
    localparam int LANE_BYTES   = 8;
    localparam int STACK_DEPTH  = 258;
    localparam int STK_AW       = 9;
    localparam int ENT_AW       = 8;
    localparam int ENT_W        = 17;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_UNDEC  = 2'd1,
        ERR_CAP    = 2'd2,
        ERR_BEYOND = 2'd3
    } err_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              sos;
        logic              lit;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

/* design/lzwd_front.sv */
`timescale 1ns / 1ps
module lzwd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lzwd_pkg::CODE_W-1:0]   s_code,
    input  logic                          s_sos,
    output lzwd_pkg::head_t               q_head,
    input  logic                          q_pop
);
    import lzwd_pkg::*;

    item_t      slot_reg [QUEUE_DEPTH];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    assign s_tready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    always_comb begin
        in_item.code = s_code;
        in_item.sos  = s_sos;
        in_item.lit  = (s_code[CODE_W-1:8] == '0);
    end

    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.item  = slot_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_item;
        end
    end

endmodule

/* design/lzwd_back.sv */
`timescale 1ns / 1ps
module lzwd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lzwd_pkg::head_t                 q_head,
    output logic                            q_pop,
    input  logic [lzwd_pkg::CAP_W-1:0]      cap,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [8*lzwd_pkg::LANE_BYTES-1:0] m_data,
    output logic [3:0]                      m_count,
    output logic                            m_last,
    output logic [1:0]                      m_err,
    output logic [lzwd_pkg::CAP_W-1:0]      m_total
);
    import lzwd_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_LOOKUP   = 9'b000000010,
        ST_PUSH     = 9'b000000100,
        ST_LIT      = 9'b000001000,
        ST_CHECK    = 9'b000010000,
        ST_EMIT_RD  = 9'b000100000,
        ST_EMIT_ACC = 9'b001000000,
        ST_OUT      = 9'b010000000,
        ST_ERR      = 9'b100000000
    } state_t;

    localparam logic [STK_AW-1:0] STACK_TOP = STK_AW'(STACK_DEPTH);
    localparam logic [NFE_W-1:0]  NFE_BASE  = NFE_W'(256);
    localparam logic [NFE_W-1:0]  NFE_LIMIT = NFE_W'(DICT_ENTRIES);

    logic [ENT_W-1:0] ent_mem [256];
    logic [7:0]       stk_mem [STACK_DEPTH];
    logic [ENT_W-1:0] ent_rdata;
    logic [7:0]       stk_rdata;
    logic             ent_we;
    logic             stk_we;
    logic [STK_AW-1:0] stk_waddr;
    logic [7:0]       stk_wdata;

    state_t            state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [SYM_W-1:0]  cur_reg, cur_next;
    logic [SYM_W-1:0]  prev_reg, prev_next;
    logic [NFE_W-1:0]  nfe_reg, nfe_next;
    logic [CAP_W-1:0]  total_reg, total_next;
    err_t              sticky_reg, sticky_next;
    err_t              err_reg, err_next;
    logic              have_reg, have_next;
    logic              kwk_reg, kwk_next;
    logic [STK_AW-1:0] pos_reg, pos_next;
    logic [STK_AW-1:0] rp_reg, rp_next;
    logic [3:0]        k_reg, k_next;
    logic [7:0]        first_reg, first_next;
    logic [63:0]       word_reg, word_next;

    logic              mv_reg, mv_next;
    logic [63:0]       md_reg, md_next;
    logic [3:0]        mc_reg, mc_next;
    logic              ml_reg, ml_next;
    logic [1:0]        me_reg, me_next;
    logic [CAP_W-1:0]  mt_reg, mt_next;

    logic              slot_free;
    assign slot_free = !mv_reg || m_ready;

    always_comb begin
        err_t             eff_sticky;
        logic             eff_have;
        logic [NFE_W-1:0] eff_nfe;
        logic [CAP_W-1:0] eff_total;
        logic [STK_AW-1:0] len;
        logic [CAP_W:0]   sum;
        logic [CAP_W-1:0] new_total;

        state_next  = state_reg;
        code_next   = code_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nfe_next    = nfe_reg;
        total_next  = total_reg;
        sticky_next = sticky_reg;
        err_next    = err_reg;
        have_next   = have_reg;
        kwk_next    = kwk_reg;
        pos_next    = pos_reg;
        rp_next     = rp_reg;
        k_next      = k_reg;
        first_next  = first_reg;
        word_next   = word_reg;
        mv_next     = mv_reg && !m_ready;
        md_next     = md_reg;
        mc_next     = mc_reg;
        ml_next     = ml_reg;
        me_next     = me_reg;
        mt_next     = mt_reg;
        q_pop       = 1'b0;
        ent_we      = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        eff_sticky  = sticky_reg;
        eff_have    = have_reg;
        eff_nfe     = nfe_reg;
        eff_total   = total_reg;
        len         = STACK_TOP - pos_reg;
        sum         = {1'b0, total_reg} + (CAP_W+1)'(len);
        new_total   = total_reg + CAP_W'(k_reg);

        case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    q_pop     = 1'b1;
                    code_next = q_head.item.code;
                    if (q_head.item.sos) begin
                        eff_sticky = ERR_NONE;
                        eff_have   = 1'b0;
                        eff_nfe    = NFE_BASE;
                        eff_total  = '0;
                    end
                    sticky_next = eff_sticky;
                    have_next   = eff_have;
                    nfe_next    = eff_nfe;
                    total_next  = eff_total;
                    if (eff_sticky != ERR_NONE) begin
                        err_next   = eff_sticky;
                        state_next = ST_ERR;
                    end else if (!eff_have) begin
                        if (!q_head.item.lit) begin
                            sticky_next = ERR_UNDEC;
                            err_next    = ERR_UNDEC;
                            state_next  = ST_ERR;
                        end else begin
                            cur_next   = q_head.item.code[SYM_W-1:0];
                            pos_next   = STACK_TOP;
                            kwk_next   = 1'b0;
                            state_next = ST_LIT;
                        end
                    end else if (q_head.item.code < CODE_W'(eff_nfe)) begin
                        cur_next   = q_head.item.code[SYM_W-1:0];
                        pos_next   = STACK_TOP;
                        kwk_next   = 1'b0;
                        state_next = q_head.item.code[8] ? ST_LOOKUP : ST_LIT;
                    end else if (q_head.item.code == CODE_W'(eff_nfe)
                                 && eff_nfe < NFE_LIMIT) begin
                        // code not yet in the table: previous string plus its head
                        cur_next   = prev_reg;
                        pos_next   = STACK_TOP - 1'b1;
                        kwk_next   = 1'b1;
                        state_next = prev_reg[8] ? ST_LOOKUP : ST_LIT;
                    end else begin
                        sticky_next = ERR_BEYOND;
                        err_next    = ERR_BEYOND;
                        state_next  = ST_ERR;
                    end
                end
            end
            ST_LOOKUP: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                stk_we     = 1'b1;
                stk_waddr  = pos_reg - 1'b1;
                stk_wdata  = ent_rdata[7:0];
                pos_next   = pos_reg - 1'b1;
                cur_next   = ent_rdata[ENT_W-1:8];
                state_next = ent_rdata[ENT_W-1] ? ST_LOOKUP : ST_LIT;
            end
            ST_LIT: begin
                stk_we     = 1'b1;
                stk_waddr  = pos_reg - 1'b1;
                stk_wdata  = cur_reg[7:0];
                pos_next   = pos_reg - 1'b1;
                first_next = cur_reg[7:0];
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sum > {1'b0, cap}) begin
                    sticky_next = ERR_CAP;
                    err_next    = ERR_CAP;
                    state_next  = ST_ERR;
                end else begin
                    if (kwk_reg) begin
                        stk_we    = 1'b1;
                        stk_waddr = STACK_TOP - 1'b1;
                        stk_wdata = first_reg;
                    end
                    if (have_reg && nfe_reg < NFE_LIMIT) begin
                        ent_we   = 1'b1;
                        nfe_next = nfe_reg + 1'b1;
                    end
                    prev_next  = code_reg[SYM_W-1:0];
                    have_next  = 1'b1;
                    rp_next    = pos_reg;
                    k_next     = '0;
                    word_next  = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_ACC;
            end
            ST_EMIT_ACC: begin
                word_next[{k_reg[2:0], 3'b000} +: 8] = stk_rdata;
                k_next  = k_reg + 1'b1;
                rp_next = rp_reg + 1'b1;
                if (k_reg == 4'(LANE_BYTES - 1) || rp_reg == STACK_TOP - 1'b1) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    mv_next    = 1'b1;
                    md_next    = word_reg;
                    mc_next    = k_reg;
                    ml_next    = (rp_reg == STACK_TOP);
                    me_next    = ERR_NONE;
                    mt_next    = new_total;
                    total_next = new_total;
                    word_next  = '0;
                    k_next     = '0;
                    state_next = (rp_reg == STACK_TOP) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    mv_next    = 1'b1;
                    md_next    = '0;
                    mc_next    = '0;
                    ml_next    = 1'b1;
                    me_next    = err_reg;
                    mt_next    = total_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            prev_reg   <= '0;
            nfe_reg    <= NFE_BASE;
            total_reg  <= '0;
            sticky_reg <= ERR_NONE;
            err_reg    <= ERR_NONE;
            have_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            prev_reg   <= prev_next;
            nfe_reg    <= nfe_next;
            total_reg  <= total_next;
            sticky_reg <= sticky_next;
            err_reg    <= err_next;
            have_reg   <= have_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        cur_reg   <= cur_next;
        kwk_reg   <= kwk_next;
        pos_reg   <= pos_next;
        rp_reg    <= rp_next;
        k_reg     <= k_next;
        first_reg <= first_next;
        word_reg  <= word_next;
        md_reg    <= md_next;
        mc_reg    <= mc_next;
        ml_reg    <= ml_next;
        me_reg    <= me_next;
        mt_reg    <= mt_next;
    end

    // dictionary: written at the next free slot, read at the chain head
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[nfe_reg[ENT_AW-1:0]] <= {prev_reg, first_reg};
        end
        ent_rdata <= ent_mem[cur_reg[ENT_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata <= stk_mem[rp_reg];
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;
    assign m_count = mc_reg;
    assign m_last  = ml_reg;
    assign m_err   = me_reg;
    assign m_total = mt_reg;

    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && me_reg != ERR_NONE) |-> (mc_reg == 4'd0 && ml_reg && md_reg == '0))
        else $error("error word carries data");

    a_ok_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && me_reg == ERR_NONE) |-> (mc_reg != 4'd0 && mc_reg <= 4'(LANE_BYTES)))
        else $error("bad byte count");

    a_nfe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (nfe_reg >= NFE_BASE && nfe_reg <= NFE_LIMIT))
        else $error("next free entry out of range");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH || state_reg == ST_LIT) |-> (pos_reg != '0))
        else $error("string stack underflow");

    a_sticky_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (sticky_reg == ERR_NONE))
        else $error("data emitted under sticky error");

endmodule

/* design/lzw_code_decompressor_unit.sv */
`timescale 1ns / 1ps
// LZW decoder for fixed 16-bit codes. Each input word is one code; tuser[0]
// starts a new stream. A code is dispatched, then each dictionary entry on its
// prefix chain is read (registered dictionary read) and pushed, then the literal
// is pushed and the capacity checked, then each output byte is read from the
// string stack and packed, and each full or final word goes to the output
// register. An error found at dispatch goes straight to its error word; a
// capacity error is found after the chain walk and the check, then sends its word.
// A two-word input queue lets codes arrive while one is
// expanded, and the output register holds a finished word while the next one
// is built.
module lzw_code_decompressor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lzwd_pkg::CAP_W-1:0]    cfg_wr_data,   // output_capacity
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,       // code
    input  logic [0:0]                    s_tuser,       // start_of_stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,       // data_bytes, byte_count,
                                                         // total_written, zero pad
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser        // error_status
);
    import lzwd_pkg::*;

    logic [CAP_W-1:0] cap_reg, cap_next;
    head_t            q_head;
    logic             q_pop;
    logic [63:0]      m_data;
    logic [3:0]       m_count;
    logic [CAP_W-1:0] m_total;

    assign cap_next = cfg_wr_en ? cfg_wr_data : cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '1;
        end else begin
            cap_reg <= cap_next;
        end
    end

    lzwd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_code   (s_tdata),
        .s_sos    (s_tuser[0]),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    lzwd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .cap     (cap_reg),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_data),
        .m_count (m_count),
        .m_last  (m_tlast),
        .m_err   (m_tuser),
        .m_total (m_total)
    );

    assign m_tdata = {4'b0000, m_total, m_count, m_data};

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import lzwd_pkg::*;

    localparam int WDOG_LIMIT = 100000;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        err_t        err;
        logic [23:0] total;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    lzw_code_decompressor_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    initial forever #5 aclk = ~aclk;

    // decoder shadow state
    logic [16:0] dict [256];
    logic [7:0]  str_buf [STACK_DEPTH];
    logic [8:0]  last_code;
    logic [9:0]  next_free;
    logic [23:0] out_total;
    err_t        sticky;
    logic        started;
    logic [23:0] capacity;

    word_t expected_words [$];
    int    errors = 0;
    int    words_seen = 0;
    int    codes_sent = 0;
    int    idle_cycles = 0;
    int    stall_mode = 0;
    bit    burst_mode = 1;

    function automatic int expand(logic [8:0] c, int top);
        int pos;
        logic [16:0] e;
        pos = top;
        while (c >= 256 && pos > 1) begin
            e = dict[c - 256];
            pos--;
            str_buf[pos] = e[7:0];
            c = e[16:8];
        end
        pos--;
        str_buf[pos] = c[7:0];
        return pos;
    endfunction

    function automatic void push_error(err_t e);
        word_t w;
        w.data = '0; w.cnt = '0; w.last = 1'b1; w.err = e; w.total = out_total;
        expected_words.push_back(w);
    endfunction

    function automatic void decode_code(logic [15:0] code, logic sos);
        int pos;
        int k;
        word_t w;
        if (sos) begin
            next_free = 10'd256; out_total = '0; sticky = ERR_NONE; started = 1'b0;
        end
        if (sticky != ERR_NONE) begin
            push_error(sticky);
            return;
        end
        if (!started) begin
            if (code >= 256) begin
                sticky = ERR_UNDEC; push_error(sticky); return;
            end
            pos = expand(code[8:0], STACK_DEPTH);
        end else if (code < next_free) begin
            pos = expand(code[8:0], STACK_DEPTH);
        end else if (code == next_free && next_free < DICT_ENTRIES) begin
            pos = expand(last_code, STACK_DEPTH - 1);
            str_buf[STACK_DEPTH-1] = str_buf[pos];
        end else begin
            sticky = ERR_BEYOND; push_error(sticky); return;
        end
        if (32'(out_total) + 32'(STACK_DEPTH - pos) > 32'(capacity)) begin
            sticky = ERR_CAP; push_error(sticky); return;
        end
        if (started && next_free < DICT_ENTRIES) begin
            dict[next_free - 256] = {last_code, str_buf[pos]};
            next_free++;
        end
        while (pos < STACK_DEPTH) begin
            w.data = '0;
            k = 0;
            while (k < 8 && pos < STACK_DEPTH) begin
                w.data[8*k +: 8] = str_buf[pos];
                k++; pos++;
            end
            out_total = out_total + 24'(k);
            w.cnt = 4'(k); w.last = (pos >= STACK_DEPTH); w.err = ERR_NONE;
            w.total = out_total;
            expected_words.push_back(w);
        end
        last_code = code[8:0];
        started = 1'b1;
    endfunction

    // result checker and stall pattern
    always @(posedge aclk) begin
        word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h last %b err %0d",
                                           m_tdata, m_tlast, m_tuser);
            end else begin
                w = expected_words.pop_front();
                if (m_tdata[63:0] !== w.data || m_tdata[67:64] !== w.cnt ||
                    m_tdata[91:68] !== w.total || m_tlast !== w.last ||
                    m_tuser !== w.err) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp data %h cnt %0d tot %0d last %b err %0d",
                                 w.data, w.cnt, w.total, w.last, w.err);
                        $display("          got data %h cnt %0d tot %0d last %b err %0d",
                                 m_tdata[63:0], m_tdata[67:64], m_tdata[91:68],
                                 m_tlast, m_tuser);
                    end
                end
            end
        end
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // watchdog: cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
    end

    // valid stays up between back-to-back words; it drops for a gap or while draining
    task automatic send_code(logic [15:0] code, logic sos);
        int gap;
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if ($urandom_range(0, 40) == 0) burst_mode = ~burst_mode;
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= sos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_code(code, sos);
        codes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [23:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        capacity = v;
    endtask

    // a valid stream: literals, existing codes and the next-free case
    task automatic send_stream(int n, bit mostly_new);
        int r;
        logic [15:0] c;
        for (int i = 0; i < n; i++) begin
            if (i == 0) c = 16'($urandom_range(0, 255));
            else begin
                r = $urandom_range(0, 9);
                if (r < 3) c = 16'($urandom_range(0, 255));
                else if (r < 8 || !mostly_new)
                    c = 16'($urandom_range(256, next_free - 1 < 256 ? 256 : next_free - 1));
                else c = 16'(next_free);
                if (c >= next_free && c != next_free) c = 16'(next_free);
            end
            send_code(c, i == 0);
        end
    endtask

    task automatic test_directed();
        send_code(16'h0000, 1'b1);
        send_code(16'h00FF, 1'b0);
        send_code(16'd256, 1'b0);
        send_code(16'd258, 1'b0);     // equals next free
        send_code(16'd259, 1'b0);     // equals next free again, chain grows
        send_code(16'd257, 1'b0);
        send_code(16'd300, 1'b0);     // beyond next free
        send_code(16'd65, 1'b0);      // sticky
        send_code(16'd256, 1'b1);     // first code not literal
        send_code(16'hFFFF, 1'b0);
        send_code(16'hFFFF, 1'b1);
        send_code(16'h00AA, 1'b1);
        send_code(16'h0055, 1'b0);
        send_code(16'hFFFF, 1'b0);
    endtask

    // chain of next-free codes reaches long strings up to the dictionary limit
    task automatic test_long_strings();
        send_code(16'd7, 1'b1);
        for (int i = 0; i < 255; i++) send_code(16'(next_free), 1'b0);
        send_code(16'd510, 1'b0);
        send_code(16'd511, 1'b0);
        send_code(16'd512, 1'b0);     // dictionary full, no entry can form
    endtask

    task automatic test_capacity();
        write_capacity(24'd0);
        send_code(16'd1, 1'b1);
        send_code(16'd2, 1'b1);
        write_capacity(24'd5);
        send_stream(6, 1'b1);
        write_capacity(24'd40);
        send_stream(10, 1'b1);
        write_capacity(24'hFFFFFF);
    endtask

    task automatic test_random();
        for (int s = 0; s < 3; s++) begin
            if ($urandom_range(0, 3) == 0)
                send_code(16'($urandom), 1'($urandom_range(0, 1)));
            send_stream($urandom_range(5, 10), 1'($urandom_range(0, 1)));
            if (s == 1) wait_drained();   // sender holds until all results are back
        end
        for (int i = 0; i < 5; i++) send_code(16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        capacity = 24'hFFFFFF;
        last_code = '0; next_free = 10'd256; out_total = '0; sticky = ERR_NONE;
        started = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_long_strings();
        test_capacity();
        test_random();
        wait_drained();
        $display("covered %0d codes, %0d result words: literals, chains, next-free,",
                 codes_sent, words_seen);
        $display("full dictionary, capacity limits and all error kinds");
        if (errors == 0 && expected_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
